/* rtl/core/clpf_pkg.sv */
// shared types, constants and helpers of the corner line pair finder
// no dependencies; imported by every module of the block

package clpf_pkg;

   localparam int COORD_W     = 14;
   localparam int MAX_LINES   = 64;
   localparam int CNT_W       = $clog2(MAX_LINES + 1);
   localparam int IDX_W       = $clog2(MAX_LINES);
   localparam int TAN_W       = 16;
   localparam int RAD_W       = 30;
   localparam int FRAC_SHIFT  = 16;
   localparam int PROD_W      = COORD_W + TAN_W;
   localparam int SQ_W        = 2 * COORD_W;
   localparam int DIST_W      = SQ_W + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = RAD_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_TAN    = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIUS = 1'd1;

   localparam logic [TAN_W-1:0] TAN_RESET = 16'd23852;
   localparam logic [RAD_W-1:0] RAD_RESET = 30'd25600;

   // x_start sits in the lowest bits, matching the stream packing
   typedef struct packed {
      logic [COORD_W-1:0] y_end;
      logic [COORD_W-1:0] x_end;
      logic [COORD_W-1:0] y_start;
      logic [COORD_W-1:0] x_start;
   } seg_type;

   localparam int SEG_W = $bits(seg_type);

   typedef enum logic [1:0] {
      CLS_NONE = 2'd0,
      CLS_H    = 2'd1,
      CLS_V    = 2'd2
   } seg_class_type;

   typedef struct packed {
      seg_type       seg;
      logic          new_frame;
      seg_class_type kind;
   } cmd_type;

   typedef struct packed {
      seg_type v_seg;
      seg_type h_seg;
   } pair_type;

   localparam int PAIR_W = $bits(pair_type);

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

/* rtl/core/corner_line_pair_finder_unit.sv */
// top level of the corner line pair finder: config registers, front end,
// command queue and back end; depends on clpf_pkg, clpf_front, clpf_fifo, clpf_back
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------------
//   req      | in        | req_tvalid/tready  | segment endpoints, new_frame in tuser
//   rsp      | out       | rsp_tvalid/tready  | horizontal + vertical segment, tlast
//   csr      | in        | csr_wen            | tan threshold (0), radius squared (1)
//
// an item holds the back end for a scan over n stored segments of the opposite
// class (n up to 64); with n = 0 or an ignored segment there is no scan. the
// store read port and the distance pipeline (read, squared distances, compare)
// walk one stored segment per cycle while the rsp side is not stalled.
// reset is synchronous: it clears the counts, queue and handshakes and loads
// the config registers with their reset values; the stores are not cleared.
// the front end and a 4-deep queue keep taking items while the back end scans;
// a stalled rsp side freezes the scan pipeline in place.

module corner_line_pair_finder_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [clpf_pkg::SEG_W-1:0]        req_tdata,  // x_start, y_start, x_end, y_end
   input  logic                              req_tuser,  // new_frame
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [clpf_pkg::PAIR_W-1:0]       rsp_tdata,  // h_x_start, h_y_start, h_x_end,
                                                         // h_y_end, v_x_start, v_y_start,
                                                         // v_x_end, v_y_end
   output logic                              rsp_tlast,  // last_in_run
   input  logic                              csr_wen,
   input  logic [clpf_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [clpf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import clpf_pkg::*;

   logic [TAN_W-1:0] tan_ff;
   logic [RAD_W-1:0] rad_ff;
   logic             q_push, q_full, q_pop, q_empty;
   cmd_type          q_cmd, q_head;
   pair_type         pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         tan_ff <= TAN_RESET;
         rad_ff <= RAD_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_TAN:    tan_ff <= csr_wdata[TAN_W-1:0];
            CSR_RADIUS: rad_ff <= csr_wdata[RAD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   clpf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .tan_threshold (tan_ff),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_seg       (seg_type'(req_tdata)),
      .req_new_frame (req_tuser),
      .q_push        (q_push),
      .q_cmd         (q_cmd),
      .q_full        (q_full)
   );

   clpf_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   clpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .radius_sq  (rad_ff),
      .q_head     (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_pair   (pair),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = PAIR_W'(pair);

endmodule

/* rtl/core/clpf_front.sv */
// front end: takes segment items, classes them by slope and hands commands on
// depends on clpf_pkg

module clpf_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [clpf_pkg::TAN_W-1:0]   tan_threshold,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  clpf_pkg::seg_type            req_seg,
   input  logic                         req_new_frame,
   output logic                         q_push,
   output clpf_pkg::cmd_type            q_cmd,
   input  logic                         q_full
);
   import clpf_pkg::*;

   logic                valid_ff, valid_in;
   seg_type             seg_ff;
   logic                nf_ff;
   logic [COORD_W-1:0]  adx, ady;
   logic [PROD_W-1:0]   lim_h, lim_v, lhs_h, lhs_v;
   seg_class_type       kind;

   assign req_tready = !valid_ff || !q_full;
   assign q_push     = valid_ff && !q_full;

   always_comb begin
      adx   = abs_diff(seg_ff.x_end, seg_ff.x_start);
      ady   = abs_diff(seg_ff.y_end, seg_ff.y_start);
      lim_h = PROD_W'(tan_threshold) * PROD_W'(adx);
      lim_v = PROD_W'(tan_threshold) * PROD_W'(ady);
      lhs_h = {ady, FRAC_SHIFT'(0)};
      lhs_v = {adx, FRAC_SHIFT'(0)};
      // horizontal wins when both tests pass
      if (lhs_h <= lim_h) begin
         kind = CLS_H;
      end else if (lhs_v <= lim_v) begin
         kind = CLS_V;
      end else begin
         kind = CLS_NONE;
      end
      q_cmd.seg       = seg_ff;
      q_cmd.new_frame = nf_ff;
      q_cmd.kind      = kind;
   end

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         seg_ff <= req_seg;
         nf_ff  <= req_new_frame;
      end
   end

endmodule

/* rtl/core/clpf_fifo.sv */
// short command queue between the front end and the pair scanner
// depends on clpf_pkg

module clpf_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clpf_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output clpf_pkg::cmd_type head,
   output logic              empty
);
   import clpf_pkg::*;

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full    = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/clpf_back.sv */
// back end: segment stores, scan of the opposite store and pair output
// depends on clpf_pkg; fed by clpf_fifo

module clpf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [clpf_pkg::RAD_W-1:0]    radius_sq,
   input  clpf_pkg::cmd_type             q_head,
   input  logic                          q_empty,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output clpf_pkg::pair_type            rsp_pair,
   output logic                          rsp_last
);
   import clpf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   seg_type hmem [MAX_LINES];
   seg_type vmem [MAX_LINES];

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   hcnt_ff, hcnt_in, vcnt_ff, vcnt_in;
   logic [CNT_W-1:0]   scan_n_ff, scan_n_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   seg_type            cur_ff;
   seg_class_type      kind_ff;
   seg_type            hrd_ff, vrd_ff;
   logic               s1_valid_ff, s1_valid_in, s1_last_ff, s1_last_in;
   logic               s2_valid_ff, s2_valid_in, s2_last_ff, s2_last_in;
   seg_type            s2_seg_ff;
   logic [SQ_W-1:0]    sq_x0_ff, sq_y0_ff, sq_x1_ff, sq_y1_ff;
   pair_type           pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in, pend_final_ff, pend_final_in;
   pair_type           rsp_pair_ff, rsp_pair_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;

   logic               adv, issue, issue_last, h_new;
   logic               hwe, vwe;
   logic [IDX_W-1:0]   waddr;
   logic [CNT_W-1:0]   hc, vc;
   seg_type            s1_seg, h_pt, v_pt;
   logic [COORD_W-1:0] dx0, dy0, dx1, dy1;
   logic [DIST_W-1:0]  dist0, dist1;
   logic               match;
   pair_type           new_pair;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_pair   = rsp_pair_ff;
   assign rsp_last   = rsp_last_ff;
   assign h_new      = (kind_ff == CLS_H);

   // stage 1: registered store read; stage 2: squared distances; then compare
   always_comb begin
      s1_seg = h_new ? vrd_ff : hrd_ff;
      h_pt   = h_new ? cur_ff : s1_seg;
      v_pt   = h_new ? s1_seg : cur_ff;
      dx0    = abs_diff(h_pt.x_start, v_pt.x_start);
      dy0    = abs_diff(h_pt.y_start, v_pt.y_start);
      dx1    = abs_diff(h_pt.x_start, v_pt.x_end);
      dy1    = abs_diff(h_pt.y_start, v_pt.y_end);
      dist0  = DIST_W'(sq_x0_ff) + DIST_W'(sq_y0_ff);
      dist1  = DIST_W'(sq_x1_ff) + DIST_W'(sq_y1_ff);
      match  = s2_valid_ff && ((RAD_W'(dist0) <= radius_sq) ||
                               (RAD_W'(dist1) <= radius_sq));
      if (h_new) begin
         new_pair.h_seg = cur_ff;
         new_pair.v_seg = s2_seg_ff;
      end else begin
         new_pair.h_seg = s2_seg_ff;
         new_pair.v_seg = cur_ff;
      end
   end

   // command sequencer
   always_comb begin
      state_in   = state_ff;
      hcnt_in    = hcnt_ff;
      vcnt_in    = vcnt_ff;
      scan_n_in  = scan_n_ff;
      idx_in     = idx_ff;
      q_pop      = 1'b0;
      hwe        = 1'b0;
      vwe        = 1'b0;
      waddr      = '0;
      issue      = 1'b0;
      issue_last = 1'b0;
      hc         = q_head.new_frame ? '0 : hcnt_ff;
      vc         = q_head.new_frame ? '0 : vcnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               hcnt_in = hc;
               vcnt_in = vc;
               case (q_head.kind)
                  CLS_H: begin
                     scan_n_in = vc;
                     waddr     = hc[IDX_W-1:0];
                     if (hc < CNT_W'(MAX_LINES)) begin
                        hwe     = 1'b1;
                        hcnt_in = hc + 1'b1;
                     end
                  end
                  CLS_V: begin
                     scan_n_in = hc;
                     waddr     = vc[IDX_W-1:0];
                     if (vc < CNT_W'(MAX_LINES)) begin
                        vwe     = 1'b1;
                        vcnt_in = vc + 1'b1;
                     end
                  end
                  default: begin
                     scan_n_in = '0;
                  end
               endcase
               idx_in = '0;
               if (q_head.kind != CLS_NONE && scan_n_in != '0) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (adv) begin
               issue      = 1'b1;
               issue_last = (CNT_W'(idx_ff) == scan_n_ff - 1'b1);
               idx_in     = idx_ff + 1'b1;
               if (issue_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff && !pend_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // pipeline advance and hold-back of one pair so the last one can be marked
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_last_in    = s1_last_ff;
      s2_valid_in   = s2_valid_ff;
      s2_last_in    = s2_last_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      pend_final_in = pend_final_ff;
      rsp_pair_in   = rsp_pair_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (adv) begin
         s1_valid_in  = issue;
         s1_last_in   = issue_last;
         s2_valid_in  = s1_valid_ff;
         s2_last_in   = s1_last_ff;
         rsp_valid_in = 1'b0;
         if (match) begin
            if (pend_valid_ff) begin
               rsp_pair_in  = pend_ff;
               rsp_last_in  = 1'b0;
               rsp_valid_in = 1'b1;
            end
            pend_in       = new_pair;
            pend_valid_in = 1'b1;
            pend_final_in = s2_last_ff;
         end else if (pend_valid_ff && ((s2_valid_ff && s2_last_ff) || pend_final_ff)) begin
            rsp_pair_in   = pend_ff;
            rsp_last_in   = 1'b1;
            rsp_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
            pend_final_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hcnt_ff       <= '0;
         vcnt_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_final_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hcnt_ff       <= hcnt_in;
         vcnt_ff       <= vcnt_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         pend_valid_ff <= pend_valid_in;
         pend_final_ff <= pend_final_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_n_ff   <= scan_n_in;
      idx_ff      <= idx_in;
      s1_last_ff  <= s1_last_in;
      s2_last_ff  <= s2_last_in;
      pend_ff     <= pend_in;
      rsp_pair_ff <= rsp_pair_in;
      rsp_last_ff <= rsp_last_in;
      if (q_pop) begin
         cur_ff  <= q_head.seg;
         kind_ff <= q_head.kind;
      end
      if (adv) begin
         s2_seg_ff <= s1_seg;
         sq_x0_ff  <= SQ_W'(dx0) * SQ_W'(dx0);
         sq_y0_ff  <= SQ_W'(dy0) * SQ_W'(dy0);
         sq_x1_ff  <= SQ_W'(dx1) * SQ_W'(dx1);
         sq_y1_ff  <= SQ_W'(dy1) * SQ_W'(dy1);
      end
   end

   // stores: at most one write at command start, one registered read per scan step
   always_ff @(posedge clock) begin
      if (hwe) begin
         hmem[waddr] <= q_head.seg;
      end
   end

   always_ff @(posedge clock) begin
      if (vwe) begin
         vmem[waddr] <= q_head.seg;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hrd_ff <= hmem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vrd_ff <= vmem[idx_ff];
      end
   end

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_valid_ff && !s2_valid_ff && !pend_valid_ff))
      else $error("scan pipeline busy while idle");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (hcnt_ff <= CNT_W'(MAX_LINES)) && (vcnt_ff <= CNT_W'(MAX_LINES)))
      else $error("store count beyond capacity");

   a_final_held: assert property (@(posedge clock) disable iff (reset)
      pend_final_ff |-> pend_valid_ff)
      else $error("final flag without held pair");

   a_last_issue: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff) |-> (state_ff == ST_DRAIN))
      else $error("last scan read issued but sequencer still scanning");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !q_pop)
      else $error("command taken while a scan is running");

endmodule
